[rtl/core/gcb_pkg.sv]
// Shared types and constants for the glyph column blitter.
package gcb_pkg;

  // Linear store address width: covers column * bytes per column plus row offsets.
  localparam int LIN_W = 17;
  // Byte counter width for a blit.
  // Height is clamped to MAX_GLYPH_BYTES, so at most one byte more is written.
  localparam int CNT_W = 4;
  localparam int NUM_DATA = 4;

  localparam logic [2:0] GLYPH_H_RST = 3'd2;
  localparam logic       INVERT_RST  = 1'b1;

  typedef enum logic [1:0] {
    OP_BLIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_GLYPH_HEIGHT = 1'b0,
    REG_INVERT       = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_BOT,
    ST_WRITE,
    ST_RESP
  } state_t;

endpackage

[rtl/core/glyph_column_blit_1bpp_unit.sv]
// Glyph column blitter over a 1bpp frame store held in a single-port memory.
//
// Input channel (in_*): one transfer per item. in_tuser is the opcode (blit,
// read byte, write byte); in_tdata carries column, pixel row, byte row and
// four glyph bytes. Result channel (out_*): one transfer per read item,
// holding the store byte. Configuration (cfg_*): index 0 glyph height in
// bytes, index 1 invert enable; always ready, write only while idle.
// Work per item, all through the one byte-wide memory port:
//   write byte: one write; read byte: one read, then the output register;
//   aligned blit: h byte writes; unaligned blit: reads of the top byte and
//   of the byte below the glyph, then h + 1 writes; h is the glyph height.
// Items are processed one at a time; in_tready is high only between items.
// After reset the store is zeroed one byte per cycle, all STORE_COLUMNS *
// BYTES_PER_COLUMN bytes (4000 by default), before the first item is taken;
// configuration writes are taken during that pass. A read result waits in the
// output register while out_tready is low; the next item can already be taken,
// but a further read stalls until the register is free.
module glyph_column_blit_1bpp_unit #(
  parameter int STORE_COLUMNS    = 250,
  parameter int BYTES_PER_COLUMN = 16,
  parameter int MAX_GLYPH_BYTES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] column, [14:8] pixel_row, [18:15] byte_row, [26:19] data0,
  // [34:27] data1, [42:35] data2, [50:43] data3, [55:51] zero
  input  logic [55:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_byte
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  localparam int STORE_SIZE = STORE_COLUMNS * BYTES_PER_COLUMN;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int NCOL       = MAX_GLYPH_BYTES + 1;
  localparam logic [gcb_pkg::LIN_W-1:0] STORE_END = gcb_pkg::LIN_W'(STORE_SIZE);
  localparam logic [gcb_pkg::LIN_W-1:0] BPC       = gcb_pkg::LIN_W'(BYTES_PER_COLUMN);
  localparam logic [gcb_pkg::CNT_W-1:0] MAXG      = gcb_pkg::CNT_W'(MAX_GLYPH_BYTES);

  // Input fields
  logic [7:0] in_column;
  logic [6:0] in_pixel_row;
  logic [3:0] in_byte_row;
  logic [7:0] din [gcb_pkg::NUM_DATA];
  gcb_pkg::opcode_t in_op;

  assign in_column    = in_tdata[7:0];
  assign in_pixel_row = in_tdata[14:8];
  assign in_byte_row  = in_tdata[18:15];
  assign din[0]       = in_tdata[26:19];
  assign din[1]       = in_tdata[34:27];
  assign din[2]       = in_tdata[42:35];
  assign din[3]       = in_tdata[50:43];
  assign in_op        = gcb_pkg::opcode_t'(in_tuser);

  // Registers
  gcb_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_addr_r;
  logic [2:0]               glyph_h_r;
  logic                     invert_r;
  logic [gcb_pkg::LIN_W-1:0] base_r;
  logic [2:0]               m_r;
  logic [gcb_pkg::CNT_W-1:0] h_r;
  logic [gcb_pkg::CNT_W-1:0] n_r;
  logic [gcb_pkg::CNT_W-1:0] wr_idx_r;
  logic [7:0]               col_r [NCOL];
  logic [7:0]               top_r;
  logic [7:0]               rd_data_r;
  logic                     rd_ok_r;
  logic                     out_valid_r;
  logic [7:0]               out_data_r;

  logic [7:0] mem [STORE_SIZE];

  // Memory port and control
  logic                      mem_we, mem_re;
  logic [ADDR_W-1:0]         mem_addr;
  logic [7:0]                mem_wdata;
  logic                      in_acc;
  logic                      clr_last;
  logic                      wr_last;
  logic                      resp_load;

  // Accept-time address and glyph preparation
  logic [gcb_pkg::LIN_W-1:0] col_off;
  logic [gcb_pkg::LIN_W-1:0] in_lin;
  logic                      in_lin_ok;
  logic [2:0]                in_m;
  logic [gcb_pkg::CNT_W-1:0] in_h;
  logic [7:0]                g [NCOL];
  logic [7:0]                col_in [NCOL];
  logic [gcb_pkg::LIN_W-1:0] bot_lin;
  logic [gcb_pkg::LIN_W-1:0] wr_lin;
  logic [7:0]                keep_low;
  logic [7:0]                wr_byte;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_acc   = in_tvalid && in_tready;
  assign clr_last = (clr_addr_r == ADDR_W'(STORE_SIZE - 1));
  assign wr_last  = (wr_idx_r == n_r - gcb_pkg::CNT_W'(1));
  assign resp_load = !out_valid_r || out_tready;

  assign in_m    = in_pixel_row[2:0];
  assign col_off = gcb_pkg::LIN_W'(in_column) * BPC;

  always_comb begin
    if (in_op == gcb_pkg::OP_BLIT) begin
      in_lin = col_off + gcb_pkg::LIN_W'(in_pixel_row[6:3]);
    end else begin
      in_lin = col_off + gcb_pkg::LIN_W'(in_byte_row);
    end
  end
  assign in_lin_ok = (in_lin < STORE_END);

  // Height 0 behaves as 1, oversize clamps to the widest glyph
  always_comb begin
    if (glyph_h_r == 3'd0) begin
      in_h = gcb_pkg::CNT_W'(1);
    end else if (gcb_pkg::CNT_W'(glyph_h_r) > MAXG) begin
      in_h = MAXG;
    end else begin
      in_h = gcb_pkg::CNT_W'(glyph_h_r);
    end
  end

  // Each output byte takes the upper bits of its own glyph byte, shifted down,
  // and the spill from the one above.
  always_comb begin
    for (int k = 0; k < NCOL; k++) begin
      g[k] = 8'h00;
      if (gcb_pkg::CNT_W'(k) < in_h) begin
        g[k] = (k < gcb_pkg::NUM_DATA) ? din[k & 3] : 8'h00;
        g[k] = g[k] ^ {8{invert_r}};
      end
    end
    for (int k = 0; k < NCOL; k++) begin
      logic [15:0] pair;
      pair      = {(k == 0) ? 8'h00 : g[(k == 0) ? 0 : k - 1], g[k]} >> in_m;
      col_in[k] = pair[7:0];
    end
  end

  assign bot_lin  = base_r + gcb_pkg::LIN_W'(h_r);
  assign wr_lin   = base_r + gcb_pkg::LIN_W'(wr_idx_r);
  assign keep_low = 8'hff >> m_r;

  always_comb begin
    wr_byte = col_r[0];
    if (m_r != 3'd0 && wr_idx_r == '0) begin
      wr_byte = wr_byte | (top_r & ~keep_low);
    end
    if (m_r != 3'd0 && wr_idx_r == h_r) begin
      wr_byte = wr_byte | (rd_data_r & keep_low);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcb_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = gcb_pkg::ST_IDLE;
      end
      gcb_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            gcb_pkg::OP_BLIT:
              state_nxt = (in_m != 3'd0) ? gcb_pkg::ST_RD_BOT : gcb_pkg::ST_WRITE;
            gcb_pkg::OP_READ: state_nxt = gcb_pkg::ST_RESP;
            default:          state_nxt = gcb_pkg::ST_IDLE;
          endcase
        end
      end
      gcb_pkg::ST_RD_BOT: state_nxt = gcb_pkg::ST_WRITE;
      gcb_pkg::ST_WRITE: begin
        if (wr_last) state_nxt = gcb_pkg::ST_IDLE;
      end
      gcb_pkg::ST_RESP: begin
        if (resp_load) state_nxt = gcb_pkg::ST_IDLE;
      end
      default: state_nxt = gcb_pkg::ST_CLEAR;
    endcase
  end

  // Outputs: handshake and memory port
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = in_lin[ADDR_W-1:0];
    mem_wdata = din[0];
    case (state_r)
      gcb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = 8'h00;
      end
      gcb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc && in_lin_ok) begin
          mem_we = (in_op == gcb_pkg::OP_WRITE);
          mem_re = (in_op == gcb_pkg::OP_BLIT) || (in_op == gcb_pkg::OP_READ);
        end
      end
      gcb_pkg::ST_RD_BOT: begin
        mem_addr = bot_lin[ADDR_W-1:0];
        mem_re   = (bot_lin < STORE_END);
      end
      gcb_pkg::ST_WRITE: begin
        mem_addr  = wr_lin[ADDR_W-1:0];
        mem_wdata = wr_byte;
        mem_we    = (wr_lin < STORE_END);
      end
      gcb_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcb_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      glyph_h_r   <= gcb_pkg::GLYPH_H_RST;
      invert_r    <= gcb_pkg::INVERT_RST;
      wr_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gcb_pkg::ST_CLEAR) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (cfg_valid && cfg_ready) begin
        case (gcb_pkg::reg_index_t'(cfg_index))
          gcb_pkg::REG_GLYPH_HEIGHT: glyph_h_r <= cfg_data;
          gcb_pkg::REG_INVERT:       invert_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (state_r == gcb_pkg::ST_WRITE) begin
        wr_idx_r <= wr_last ? '0 : wr_idx_r + gcb_pkg::CNT_W'(1);
      end
      if (state_r == gcb_pkg::ST_RESP && resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r  <= in_lin;
      m_r     <= in_m;
      h_r     <= in_h;
      n_r     <= (in_m != 3'd0) ? in_h + gcb_pkg::CNT_W'(1) : in_h;
      rd_ok_r <= in_lin_ok;
    end
    if (state_r == gcb_pkg::ST_RD_BOT) top_r <= rd_data_r;
    if (state_r == gcb_pkg::ST_RESP && resp_load) begin
      out_data_r <= rd_ok_r ? rd_data_r : 8'h00;
    end
    if (in_acc) begin
      for (int k = 0; k < NCOL; k++) col_r[k] <= col_in[k];
    end else if (state_r == gcb_pkg::ST_WRITE) begin
      // shift so the byte due next always sits at the bottom slot
      for (int k = 0; k < NCOL - 1; k++) col_r[k] <= col_r[k + 1];
      col_r[NCOL-1] <= 8'h00;
    end
  end

endmodule
